// ===== rtl/etp_pkg.sv =====
// Shared types, constants and a helper function for the throttle pulse block.
package etp_pkg;

    localparam int CNT_W = 16;
    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

    localparam int PULSE_W = 12;
    localparam int TIME_W  = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    // Magnitude of speed times range stays below 2**27, so this reciprocal is exact.
    localparam int       MAG_W     = 27;
    localparam int       RECIP_SH  = 37;
    localparam int       QUO_W     = 18;
    localparam longint   RECIP_VAL = ((64'd1 << RECIP_SH) + 64'd999) / 64'd1000;
    localparam logic [27:0] RECIP  = RECIP_VAL[27:0];

    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_CAL  = 2'd2;

    localparam logic [CFG_AW-1:0] REG_MIN_PULSE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_PULSE = 3'd1;
    localparam logic [CFG_AW-1:0] REG_NEUTRAL   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SILENCE   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_POLL      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ARM_DELAY = 3'd5;
    localparam logic [CFG_AW-1:0] REG_CAL_HIGH  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_CAL_LOW   = 3'd7;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2000;
    localparam logic [PULSE_W-1:0] NEUTRAL_RST   = 12'd1500;
    localparam logic [TIME_W-1:0]  SILENCE_RST   = 16'd500;
    localparam logic [TIME_W-1:0]  POLL_RST      = 16'd100;
    localparam logic [TIME_W-1:0]  ARM_DELAY_RST = 16'd3000;
    localparam logic [TIME_W-1:0]  CAL_HIGH_RST  = 16'd10000;
    localparam logic [TIME_W-1:0]  CAL_LOW_RST   = 16'd5000;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_MAP,
        OP_NEUTRAL,
        OP_MAX,
        OP_MIN
    } pulse_op_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] throttle;
    } cmd_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               armed;
        logic               calibrating;
        logic               calib_done;
        logic               timed_out;
    } res_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_max;
        logic [PULSE_W-1:0] pulse_neutral;
        logic [TIME_W-1:0]  silence_limit_ms;
        logic [TIME_W-1:0]  poll_period_ms;
        logic [TIME_W-1:0]  arm_delay_ms;
        logic [TIME_W-1:0]  calib_high_ms;
        logic [TIME_W-1:0]  calib_low_ms;
    } cfg_t;

    // Per-item decision from the sequencer, carried down the datapath.
    typedef struct packed {
        pulse_op_t op;
        logic      armed;
        logic      calibrating;
        logic      calib_done;
        logic      timed_out;
    } item_info_t;

    // Upper clamp first, then lower, so the lower bound wins when they cross.
    function automatic logic [PULSE_W-1:0] clamp_pulse(
        input logic signed [19:0]   v,
        input logic [PULSE_W-1:0]   lo,
        input logic [PULSE_W-1:0]   hi
    );
        logic signed [19:0] t;
        logic signed [19:0] lo_s;
        logic signed [19:0] hi_s;
        lo_s = $signed({8'b0, lo});
        hi_s = $signed({8'b0, hi});
        t    = v;
        if (t > hi_s)
        begin
            t = hi_s;
        end
        if (t < lo_s)
        begin
            t = lo_s;
        end
        return t[PULSE_W-1:0];
    endfunction

    localparam logic [PULSE_W-1:0] PULSE_RST =
        clamp_pulse($signed({8'b0, NEUTRAL_RST}), MIN_PULSE_RST, MAX_PULSE_RST);

endpackage

// ===== rtl/etp_cfg.sv =====
// Configuration register file for the throttle pulse block.
module etp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [etp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [etp_pkg::CFG_DW-1:0]    cfg_wdata,
    output etp_pkg::cfg_t                 cfg
);

    etp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min        <= etp_pkg::MIN_PULSE_RST;
            cfg_reg.pulse_max        <= etp_pkg::MAX_PULSE_RST;
            cfg_reg.pulse_neutral    <= etp_pkg::NEUTRAL_RST;
            cfg_reg.silence_limit_ms <= etp_pkg::SILENCE_RST;
            cfg_reg.poll_period_ms   <= etp_pkg::POLL_RST;
            cfg_reg.arm_delay_ms     <= etp_pkg::ARM_DELAY_RST;
            cfg_reg.calib_high_ms    <= etp_pkg::CAL_HIGH_RST;
            cfg_reg.calib_low_ms     <= etp_pkg::CAL_LOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                etp_pkg::REG_MIN_PULSE: cfg_reg.pulse_min        <= cfg_wdata[11:0];
                etp_pkg::REG_MAX_PULSE: cfg_reg.pulse_max        <= cfg_wdata[11:0];
                etp_pkg::REG_NEUTRAL:   cfg_reg.pulse_neutral    <= cfg_wdata[11:0];
                etp_pkg::REG_SILENCE:   cfg_reg.silence_limit_ms <= cfg_wdata;
                etp_pkg::REG_POLL:      cfg_reg.poll_period_ms   <= cfg_wdata;
                etp_pkg::REG_ARM_DELAY: cfg_reg.arm_delay_ms     <= cfg_wdata;
                etp_pkg::REG_CAL_HIGH:  cfg_reg.calib_high_ms    <= cfg_wdata;
                etp_pkg::REG_CAL_LOW:   cfg_reg.calib_low_ms     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/etp_ctrl.sv =====
// Phase sequencer: arming delay, silence failsafe, poll timer and calibration.
module etp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            action,
    input  etp_pkg::cfg_t         cfg,
    output etp_pkg::item_info_t   info
);

    typedef enum logic [1:0] {
        PH_ARMING,
        PH_ARMED,
        PH_CAL_HIGH,
        PH_CAL_LOW
    } phase_t;

    localparam logic [etp_pkg::CNT_W-1:0] CNT_ONE = etp_pkg::CNT_W'(1);

    phase_t                       phase_reg, phase_next;
    logic [etp_pkg::CNT_W-1:0]    timer_reg, timer_next;
    logic [etp_pkg::CNT_W-1:0]    silence_reg, silence_next;
    logic [etp_pkg::CNT_W-1:0]    poll_reg, poll_next;

    logic [etp_pkg::CNT_W-1:0]    timer_inc, silence_inc, poll_inc;
    logic [etp_pkg::CMP_W-1:0]    timer_cmp, silence_cmp, poll_cmp;
    logic [etp_pkg::TIME_W-1:0]   period;
    logic                         poll_hit;

    // Counters saturate at all ones.
    assign timer_inc   = (&timer_reg)   ? timer_reg   : timer_reg + CNT_ONE;
    assign silence_inc = (&silence_reg) ? silence_reg : silence_reg + CNT_ONE;
    assign poll_inc    = (&poll_reg)    ? poll_reg    : poll_reg + CNT_ONE;

    assign timer_cmp   = etp_pkg::CMP_W'(timer_inc);
    assign silence_cmp = etp_pkg::CMP_W'(silence_inc);
    assign poll_cmp    = etp_pkg::CMP_W'(poll_inc);

    // A zero poll period behaves as a period of one tick.
    assign period   = (cfg.poll_period_ms == '0) ? etp_pkg::TIME_W'(1) : cfg.poll_period_ms;
    assign poll_hit = poll_cmp >= etp_pkg::CMP_W'(period);

    always_comb
    begin
        phase_next       = phase_reg;
        timer_next       = timer_reg;
        silence_next     = silence_reg;
        poll_next        = poll_reg;
        info.op          = etp_pkg::OP_HOLD;
        info.calib_done  = 1'b0;
        info.timed_out   = 1'b0;

        if (accept)
        begin
            case (action)
                etp_pkg::ACT_CMD:
                begin
                    if (phase_reg == PH_ARMING)
                    begin
                        silence_next = '0;
                    end
                    else if (phase_reg == PH_ARMED)
                    begin
                        silence_next = '0;
                        info.op      = etp_pkg::OP_MAP;
                    end
                end
                etp_pkg::ACT_TICK:
                begin
                    if (phase_reg == PH_ARMING)
                    begin
                        if (timer_cmp >= etp_pkg::CMP_W'(cfg.arm_delay_ms))
                        begin
                            phase_next   = PH_ARMED;
                            timer_next   = '0;
                            silence_next = '0;
                            poll_next    = '0;
                        end
                        else
                        begin
                            timer_next = timer_inc;
                        end
                    end
                    else
                    begin
                        silence_next = silence_inc;
                        poll_next    = poll_hit ? '0 : poll_inc;
                        case (phase_reg)
                            PH_ARMED:
                            begin
                                if (poll_hit &&
                                    silence_cmp > etp_pkg::CMP_W'(cfg.silence_limit_ms))
                                begin
                                    info.op        = etp_pkg::OP_NEUTRAL;
                                    info.timed_out = 1'b1;
                                end
                            end
                            PH_CAL_HIGH:
                            begin
                                if (timer_cmp >= etp_pkg::CMP_W'(cfg.calib_high_ms))
                                begin
                                    phase_next = PH_CAL_LOW;
                                    timer_next = '0;
                                    info.op    = etp_pkg::OP_MIN;
                                end
                                else
                                begin
                                    timer_next = timer_inc;
                                end
                            end
                            PH_CAL_LOW:
                            begin
                                if (timer_cmp >= etp_pkg::CMP_W'(cfg.calib_low_ms))
                                begin
                                    phase_next      = PH_ARMED;
                                    timer_next      = '0;
                                    info.calib_done = 1'b1;
                                end
                                else
                                begin
                                    timer_next = timer_inc;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                etp_pkg::ACT_CAL:
                begin
                    if (phase_reg == PH_ARMED)
                    begin
                        phase_next = PH_CAL_HIGH;
                        timer_next = '0;
                        info.op    = etp_pkg::OP_MAX;
                    end
                end
                default: ;
            endcase
        end

        info.armed       = phase_next != PH_ARMING;
        info.calibrating = (phase_next == PH_CAL_HIGH) || (phase_next == PH_CAL_LOW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_ARMING;
            timer_reg   <= '0;
            silence_reg <= '0;
            poll_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            silence_reg <= silence_next;
            poll_reg    <= poll_next;
        end
    end

endmodule

// ===== rtl/etp_map.sv =====
// Three-stage pulse datapath: speed scaling, divide by 1000, clamp and result register.
module etp_map (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    output logic                  accept,
    input  logic signed [15:0]    throttle,
    input  etp_pkg::item_info_t   info,
    input  etp_pkg::cfg_t         cfg,
    output logic                  res_valid,
    input  logic                  res_stall,
    output etp_pkg::res_t         res
);

    logic rdy1, rdy2, rdy3;

    // Stage 1: magnitude of speed times range.
    logic                          v1_reg;
    logic [etp_pkg::MAG_W-1:0]     mag_reg;
    logic                          neg1_reg;
    etp_pkg::item_info_t           info1_reg;

    // Stage 2: quotient by 1000.
    logic                          v2_reg;
    logic [etp_pkg::QUO_W-1:0]     quo_reg;
    logic                          neg2_reg;
    etp_pkg::item_info_t           info2_reg;

    // Stage 3: result register.
    logic                          v3_reg;
    logic [etp_pkg::PULSE_W-1:0]   pulse_reg, pulse_next;
    logic                          armed_reg, cal_reg, done_reg, tout_reg;

    logic signed [12:0]            range;
    logic signed [16:0]            speed_x;
    logic signed [16:0]            speed_abs_x;
    logic signed [12:0]            range_abs_x;
    logic [27:0]                   mag_full;
    logic [54:0]                   recip_prod;
    logic signed [19:0]            quo_s;
    logic signed [19:0]            mapped;

    // A stage takes new data when it is empty or its content moves on.
    assign rdy3      = !v3_reg || !res_stall;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign cmd_stall = !rdy1;
    assign accept    = cmd_valid && rdy1;

    assign range       = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
    assign speed_x     = {throttle[15], throttle};
    assign speed_abs_x = throttle[15] ? -speed_x : speed_x;
    assign range_abs_x = range[12] ? -range : range;
    assign mag_full    = speed_abs_x[15:0] * range_abs_x[11:0];

    assign recip_prod  = mag_reg * etp_pkg::RECIP;

    assign quo_s  = neg2_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
    assign mapped = $signed({8'b0, cfg.pulse_min}) + quo_s;

    always_comb
    begin
        case (info2_reg.op)
            etp_pkg::OP_MAP:
                pulse_next = etp_pkg::clamp_pulse(mapped, cfg.pulse_min,
                                                  cfg.pulse_max);
            etp_pkg::OP_NEUTRAL:
                pulse_next = etp_pkg::clamp_pulse($signed({8'b0, cfg.pulse_neutral}),
                                                  cfg.pulse_min, cfg.pulse_max);
            etp_pkg::OP_MAX:
                pulse_next = etp_pkg::clamp_pulse($signed({8'b0, cfg.pulse_max}),
                                                  cfg.pulse_min, cfg.pulse_max);
            etp_pkg::OP_MIN:
                pulse_next = etp_pkg::clamp_pulse($signed({8'b0, cfg.pulse_min}),
                                                  cfg.pulse_min, cfg.pulse_max);
            default:
                pulse_next = pulse_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            pulse_reg <= etp_pkg::PULSE_RST;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= accept;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
                if (v2_reg)
                begin
                    pulse_reg <= pulse_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mag_reg   <= mag_full[etp_pkg::MAG_W-1:0];
            neg1_reg  <= throttle[15] ^ range[12];
            info1_reg <= info;
        end
        if (rdy2)
        begin
            quo_reg   <= recip_prod[54:etp_pkg::RECIP_SH];
            neg2_reg  <= neg1_reg;
            info2_reg <= info1_reg;
        end
        if (rdy3)
        begin
            armed_reg <= info2_reg.armed;
            cal_reg   <= info2_reg.calibrating;
            done_reg  <= info2_reg.calib_done;
            tout_reg  <= info2_reg.timed_out;
        end
    end

    assign res_valid       = v3_reg;
    assign res.pulse_width = pulse_reg;
    assign res.armed       = armed_reg;
    assign res.calibrating = cal_reg;
    assign res.calib_done  = done_reg;
    assign res.timed_out   = tout_reg;

endmodule

// ===== rtl/esc_throttle_pulse_failsafe.sv =====
// Top level of the throttle pulse generator with arming delay and failsafe.
//
// Usage: each transfer on the cmd channel carries an action (throttle command,
// one millisecond tick or calibration request) and a signed per-mille speed.
// Every accepted transfer yields exactly one transfer on the res channel with
// the current pulse width and the armed, calibrating, calib_done and
// timed_out flags, in the order the items were accepted.
// The accepting edge loads stage 1, then the item moves on to stage 2 and to
// the stage 3 result register that drives res_valid. While cmd_stall is low,
// one item is accepted per cycle. The depth is set by the scaling datapath:
// one multiplier stage for speed times range, one reciprocal multiplier stage
// for the divide by 1000, and the clamp stage that loads the result register.
// While res_stall is high the three stages keep filling, so cmd_stall rises
// only when all of them hold items; results are never dropped.
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at once
// and belong to idle periods. After rst_n is released the registers hold
// their defaults, the block is arming, and the pulse sits at neutral.
module esc_throttle_pulse_failsafe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  etp_pkg::cmd_t               cmd,
    output logic                        res_valid,
    input  logic                        res_stall,
    output etp_pkg::res_t               res,
    input  logic                        cfg_we,
    input  logic [etp_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [etp_pkg::CFG_DW-1:0]  cfg_wdata
);

    etp_pkg::cfg_t        cfg;
    etp_pkg::item_info_t  info;
    logic                 accept;

    etp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    etp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .action (cmd.action),
        .cfg    (cfg),
        .info   (info)
    );

    etp_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .accept    (accept),
        .throttle  (cmd.throttle),
        .info      (info),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== rtl/etp_checker.sv =====
// Port-level assertions for the throttle pulse block, bound to the top level.
module etp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_stall,
    input  logic                        res_valid,
    input  logic                        res_stall,
    input  etp_pkg::res_t               res
);

    // A stalled result stays valid and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // The input side only backs up when the output is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("input stalled while output can move");

    a_cal_armed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.calibrating |-> res.armed)
        else $error("calibrating while not armed");

    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.calib_done |-> res.armed && !res.calibrating && !res.timed_out)
        else $error("calibration done flag in wrong state");

    a_tout_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.timed_out |-> res.armed && !res.calibrating)
        else $error("timeout flagged outside armed phase");

endmodule

bind esc_throttle_pulse_failsafe etp_checker u_etp_checker (.*);

// ===== tb/etp_checker.sv =====
// Checker that predicts the status report for every throttle transfer and compares it.
module etp_scoreboard (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_stall,
    input  etp_pkg::cmd_t               cmd,
    input  logic                        res_valid,
    input  logic                        res_stall,
    input  etp_pkg::res_t               res,
    input  logic                        cfg_we,
    input  logic [etp_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [etp_pkg::CFG_DW-1:0]  cfg_wdata,
    output int                          fail_count,
    output int                          reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_MAX    = (1 << etp_pkg::CNT_W) - 1;
    localparam int          REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        ARMING,
        ARMED,
        CAL_HIGH,
        CAL_LOW
    } esc_phase_t;

    etp_pkg::cfg_t               regs;
    esc_phase_t                  stage;
    int unsigned                 stage_timer;
    int unsigned                 quiet_ms;
    int unsigned                 poll_ms;
    logic [etp_pkg::PULSE_W-1:0] pulse_now;
    etp_pkg::res_t               status_due[$];

    // The timers stick at their top value instead of wrapping.
    function automatic int unsigned bump(input int unsigned v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    // Upper bound is applied first, so the lower bound wins when the two cross.
    function automatic logic [etp_pkg::PULSE_W-1:0] fit_pulse(input longint v);
        longint t;
        t = v;
        if (t > longint'(regs.pulse_max))
            t = longint'(regs.pulse_max);
        if (t < longint'(regs.pulse_min))
            t = longint'(regs.pulse_min);
        return t[etp_pkg::PULSE_W-1:0];
    endfunction

    task automatic restart_model();
        regs.pulse_min        = etp_pkg::MIN_PULSE_RST;
        regs.pulse_max        = etp_pkg::MAX_PULSE_RST;
        regs.pulse_neutral    = etp_pkg::NEUTRAL_RST;
        regs.silence_limit_ms = etp_pkg::SILENCE_RST;
        regs.poll_period_ms   = etp_pkg::POLL_RST;
        regs.arm_delay_ms     = etp_pkg::ARM_DELAY_RST;
        regs.calib_high_ms    = etp_pkg::CAL_HIGH_RST;
        regs.calib_low_ms     = etp_pkg::CAL_LOW_RST;
        stage       = ARMING;
        stage_timer = 0;
        quiet_ms    = 0;
        poll_ms     = 0;
        pulse_now   = fit_pulse(longint'(etp_pkg::NEUTRAL_RST));
        status_due.delete();
    endtask

    task automatic step_throttle(input etp_pkg::cmd_t c, output etp_pkg::res_t r);
        longint      span;
        longint      target;
        int unsigned period;
        logic        poll_now;
        r = '0;
        case (c.action)
            etp_pkg::ACT_CMD:
            begin
                if (stage == ARMING)
                    quiet_ms = 0;
                else if (stage == ARMED)
                begin
                    // Exact signed product; the divide truncates toward zero.
                    span   = longint'(regs.pulse_max) - longint'(regs.pulse_min);
                    target = longint'(regs.pulse_min)
                             + (longint'($signed(c.throttle)) * span) / 1000;
                    quiet_ms  = 0;
                    pulse_now = fit_pulse(target);
                end
            end
            etp_pkg::ACT_TICK:
            begin
                if (stage == ARMING)
                begin
                    stage_timer = bump(stage_timer);
                    if (stage_timer >= regs.arm_delay_ms)
                    begin
                        stage       = ARMED;
                        stage_timer = 0;
                        quiet_ms    = 0;
                        poll_ms     = 0;
                    end
                end
                else
                begin
                    period   = (regs.poll_period_ms == 0) ? 1 : regs.poll_period_ms;
                    poll_now = 1'b0;
                    quiet_ms = bump(quiet_ms);
                    poll_ms  = bump(poll_ms);
                    if (poll_ms >= period)
                    begin
                        poll_ms  = 0;
                        poll_now = 1'b1;
                    end
                    case (stage)
                        ARMED:
                        begin
                            if (poll_now && quiet_ms > regs.silence_limit_ms)
                            begin
                                pulse_now   = fit_pulse(longint'(regs.pulse_neutral));
                                r.timed_out = 1'b1;
                            end
                        end
                        CAL_HIGH:
                        begin
                            stage_timer = bump(stage_timer);
                            if (stage_timer >= regs.calib_high_ms)
                            begin
                                stage       = CAL_LOW;
                                stage_timer = 0;
                                pulse_now   = fit_pulse(longint'(regs.pulse_min));
                            end
                        end
                        default:
                        begin
                            stage_timer = bump(stage_timer);
                            if (stage_timer >= regs.calib_low_ms)
                            begin
                                stage        = ARMED;
                                stage_timer  = 0;
                                r.calib_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
            etp_pkg::ACT_CAL:
            begin
                if (stage == ARMED)
                begin
                    stage       = CAL_HIGH;
                    stage_timer = 0;
                    pulse_now   = fit_pulse(longint'(regs.pulse_max));
                end
            end
            default:
            begin
            end
        endcase
        r.pulse_width = pulse_now;
        r.armed       = (stage != ARMING);
        r.calibrating = (stage == CAL_HIGH) || (stage == CAL_LOW);
    endtask

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        etp_pkg::res_t want;
        if (!rst_n)
        begin
            restart_model();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    etp_pkg::REG_MIN_PULSE:
                        regs.pulse_min        = cfg_wdata[etp_pkg::PULSE_W-1:0];
                    etp_pkg::REG_MAX_PULSE:
                        regs.pulse_max        = cfg_wdata[etp_pkg::PULSE_W-1:0];
                    etp_pkg::REG_NEUTRAL:
                        regs.pulse_neutral    = cfg_wdata[etp_pkg::PULSE_W-1:0];
                    etp_pkg::REG_SILENCE:
                        regs.silence_limit_ms = cfg_wdata[etp_pkg::TIME_W-1:0];
                    etp_pkg::REG_POLL:
                        regs.poll_period_ms   = cfg_wdata[etp_pkg::TIME_W-1:0];
                    etp_pkg::REG_ARM_DELAY:
                        regs.arm_delay_ms     = cfg_wdata[etp_pkg::TIME_W-1:0];
                    etp_pkg::REG_CAL_HIGH:
                        regs.calib_high_ms    = cfg_wdata[etp_pkg::TIME_W-1:0];
                    etp_pkg::REG_CAL_LOW:
                        regs.calib_low_ms     = cfg_wdata[etp_pkg::TIME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd_valid && !cmd_stall)
            begin
                step_throttle(cmd, want);
                status_due.push_back(want);
            end
            if (res_valid && !res_stall)
            begin
                if (status_due.size() == 0)
                    flag_failure({$sformatf("status transfer with nothing expected at %0t: ",
                                            $time),
                                  $sformatf("pulse %0d armed %b cal %b done %b timeout %b",
                                            res.pulse_width, res.armed, res.calibrating,
                                            res.calib_done, res.timed_out)});
                else
                begin
                    want = status_due.pop_front();
                    if (res.pulse_width !== want.pulse_width || res.armed !== want.armed
                        || res.calibrating !== want.calibrating
                        || res.calib_done !== want.calib_done
                        || res.timed_out !== want.timed_out)
                        flag_failure({$sformatf("status mismatch at %0t: ", $time),
                                      $sformatf("expected pulse %0d armed %b cal %b ",
                                                want.pulse_width, want.armed,
                                                want.calibrating),
                                      $sformatf("done %b timeout %b, ",
                                                want.calib_done, want.timed_out),
                                      $sformatf("got pulse %0d armed %b cal %b ",
                                                res.pulse_width, res.armed,
                                                res.calibrating),
                                      $sformatf("done %b timeout %b",
                                                res.calib_done, res.timed_out)});
                end
            end
        end
        reports_due = status_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the throttle pulse block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD      = 10;
    localparam int         RESET_CYCLES    = 6;
    localparam int         ITEMS_PER_PHASE = 255;
    localparam int         HOLD_CYCLES     = 60;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         WATCHDOG_CYCLES = 300000;
    // Unused action code; the block only reports its current status.
    localparam logic [1:0] ACT_NONE        = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cmd_valid;
    logic                        cmd_stall;
    etp_pkg::cmd_t               cmd;
    logic                        res_valid;
    logic                        res_stall;
    etp_pkg::res_t               res;
    logic                        cfg_we;
    logic [etp_pkg::CFG_AW-1:0]  cfg_addr;
    logic [etp_pkg::CFG_DW-1:0]  cfg_wdata;
    int                          fail_count;
    int                          reports_due;
    bit                          hold_go = 1'b0;
    bit                          quiet   = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    esc_throttle_pulse_failsafe uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    etp_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    function automatic etp_pkg::cfg_t make_setting(input int lo, input int hi, input int mid,
                                                   input int silence, input int poll,
                                                   input int arm, input int cal_hi,
                                                   input int cal_lo);
        etp_pkg::cfg_t s;
        s.pulse_min        = lo[etp_pkg::PULSE_W-1:0];
        s.pulse_max        = hi[etp_pkg::PULSE_W-1:0];
        s.pulse_neutral    = mid[etp_pkg::PULSE_W-1:0];
        s.silence_limit_ms = silence[etp_pkg::TIME_W-1:0];
        s.poll_period_ms   = poll[etp_pkg::TIME_W-1:0];
        s.arm_delay_ms     = arm[etp_pkg::TIME_W-1:0];
        s.calib_high_ms    = cal_hi[etp_pkg::TIME_W-1:0];
        s.calib_low_ms     = cal_lo[etp_pkg::TIME_W-1:0];
        return s;
    endfunction

    task automatic put_reg(input logic [etp_pkg::CFG_AW-1:0] idx,
                           input logic [etp_pkg::CFG_DW-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_setting(input etp_pkg::cfg_t s);
        cfg_we <= 1'b1;
        put_reg(etp_pkg::REG_MIN_PULSE, etp_pkg::CFG_DW'(s.pulse_min));
        put_reg(etp_pkg::REG_MAX_PULSE, etp_pkg::CFG_DW'(s.pulse_max));
        put_reg(etp_pkg::REG_NEUTRAL,   etp_pkg::CFG_DW'(s.pulse_neutral));
        put_reg(etp_pkg::REG_SILENCE,   s.silence_limit_ms);
        put_reg(etp_pkg::REG_POLL,      s.poll_period_ms);
        put_reg(etp_pkg::REG_ARM_DELAY, s.arm_delay_ms);
        put_reg(etp_pkg::REG_CAL_HIGH,  s.calib_high_ms);
        put_reg(etp_pkg::REG_CAL_LOW,   s.calib_low_ms);
        cfg_we <= 1'b0;
    endtask

    // Offers one item, sometimes after a gap, and returns at the edge of its transfer.
    task automatic send_op(input logic [1:0] act, input int speed);
        etp_pkg::cmd_t c;
        c.action   = act;
        c.throttle = speed[15:0];
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Waits until every expected status has come back, then lets the pipeline settle.
    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (reports_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_speed();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 2200)) - 1100;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return 32767;
                    2: return -1000;
                    3: return 1000;
                    4: return -1001;
                    default: return 0;
                endcase
            end
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic run_directed();
        // While arming, a command only restarts the silence count and calibration is refused.
        send_op(etp_pkg::ACT_CMD, 500);
        send_op(etp_pkg::ACT_CAL, 0);
        send_op(ACT_NONE, -1);
        repeat (3) send_op(etp_pkg::ACT_TICK, 0);
        send_op(etp_pkg::ACT_CMD, 1000);
        send_op(etp_pkg::ACT_CMD, -1000);
        send_op(etp_pkg::ACT_CMD, -32768);
        send_op(etp_pkg::ACT_CMD, 32767);
        send_op(etp_pkg::ACT_CMD, 0);
        send_op(etp_pkg::ACT_CMD, 500);
        send_op(etp_pkg::ACT_CMD, -1);
        send_op(etp_pkg::ACT_CMD, 1);
        // Silence runs past its limit, so the second poll forces neutral.
        repeat (4) send_op(etp_pkg::ACT_TICK, 32'hFFFF);
        send_op(etp_pkg::ACT_CAL, 0);
        send_op(etp_pkg::ACT_CMD, 1000);
        send_op(etp_pkg::ACT_CAL, 0);
        repeat (3) send_op(etp_pkg::ACT_TICK, 0);
    endtask

    task automatic run_random(input int count);
        int sent;
        int run;
        sent = 0;
        while (sent < count)
        begin
            run = 0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    send_op(etp_pkg::ACT_CMD, pick_speed());
                    sent++;
                end
                8, 9, 10, 11, 12: run = $urandom_range(1, 8);
                13, 14:           run = $urandom_range(10, 40);
                15, 16:
                begin
                    // A calibration request followed by a random run of up to 20 ticks.
                    send_op(etp_pkg::ACT_CAL, $urandom);
                    sent++;
                    run = $urandom_range(1, 20);
                end
                17:
                begin
                    send_op(ACT_NONE, $urandom);
                    sent++;
                end
                18:
                begin
                    send_op(etp_pkg::ACT_CAL, $urandom);
                    sent++;
                end
                default: run = 1;
            endcase
            repeat (run) send_op(etp_pkg::ACT_TICK, $urandom);
            sent += run;
        end
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_setting(make_setting(1000, 2000, 1500, 3, 2, 3, 2, 1));
        run_directed();
        drain();

        load_setting(make_setting(1000, 2000, 1500, 20, 5, 65535, 6, 4));
        hold_go = 1'b1;
        run_random(ITEMS_PER_PHASE);
        drain();

        // Lowest durations: every tick polls, calibration phases end at once.
        load_setting(make_setting(0, 4095, 4095, 0, 0, 0, 0, 0));
        run_random(ITEMS_PER_PHASE);
        drain();

        // Crossed bounds: the lower bound wins.
        load_setting(make_setting(3000, 500, 100, 7, 3, 1, 1, 2));
        run_random(ITEMS_PER_PHASE);
        drain();

        repeat (2)
        begin
            load_setting(make_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), $urandom_range(0, 40),
                                      $urandom_range(0, 10), $urandom,
                                      $urandom_range(0, 15), $urandom_range(0, 15)));
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        // Highest durations, with both channels running flat out.
        quiet = 1'b1;
        load_setting(make_setting(0, 4095, 2048, 65535, 65535, 65535, 65535, 65535));
        run_random(ITEMS_PER_PHASE);
        drain();

        if (fail_count == 0)
            $display("PASS esc_throttle_pulse_failsafe");
        else
            $display("FAIL esc_throttle_pulse_failsafe");
        $finish;
    end

    // Status receiver: random stall bursts, plus one long hold-off so the pipeline backs up.
    initial
    begin : receiver
        int  span;
        logic long_hold_done;
        res_stall      = 1'b0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_go && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                res_stall     <= 1'b1;
                span           = HOLD_CYCLES;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                span       = $urandom_range(1, 15);
            end
            else
            begin
                res_stall <= 1'b0;
                span       = $urandom_range(1, 20);
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("FAIL esc_throttle_pulse_failsafe");
        $finish;
    end

endmodule
